// ----- rtl/core/fpd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpd_pkg
// Shared types and constants of the five-point derivative filter.
// ----------------------------------------------------------------------------
package fpd_pkg;

    // Default sample width and fixed result width (4 fraction bits).
    localparam int SAMPLE_W_DEF = 16;
    localparam int OUT_W        = 23;

    // Stencil select codes held in the order register.
    localparam logic ORDER_FIRST  = 1'b0;   // taps -1, 8, 0, -8, 1
    localparam logic ORDER_SECOND = 1'b1;   // taps -1, 16, -30, 16, -1

    // Control that travels beside the data of each pipeline stage.
    typedef struct packed {
        logic valid;
        logic is_final;
    } fpd_ctrl_t;

    // Front end status, for checking.
    typedef struct packed {
        logic flushing;
    } fpd_fe_status_t;

endpackage

// ----- rtl/core/fpd_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpd_window
// Sample window, position count and end-of-vector flush. Issues at most one stencil
// job per cycle, while adv is high, into the job register.
// ----------------------------------------------------------------------------
module fpd_window
    import fpd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  logic                           s_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample,
    input  logic                           s_last,
    output logic                           s_ready,
    output fpd_ctrl_t                      job_ctrl,
    output logic signed [SAMPLE_WIDTH-1:0] op_a,
    output logic signed [SAMPLE_WIDTH-1:0] op_b,
    output logic signed [SAMPLE_WIDTH-1:0] op_c,
    output logic signed [SAMPLE_WIDTH-1:0] op_d,
    output logic signed [SAMPLE_WIDTH-1:0] op_e,
    output fpd_fe_status_t                 status
);

    logic signed [SAMPLE_WIDTH-1:0] win_reg [4];
    logic signed [SAMPLE_WIDTH-1:0] win_next [4];
    logic [1:0]                     count_reg, count_next;
    logic [1:0]                     flush_reg, flush_next;   // jobs still to flush
    logic signed [SAMPLE_WIDTH-1:0] pad_reg, pad_next;       // right-edge sample

    fpd_ctrl_t                      job_ctrl_reg;
    logic signed [SAMPLE_WIDTH-1:0] job_op_reg [5];

    logic                           accept;
    logic                           job_valid;
    logic                           job_final;
    logic signed [SAMPLE_WIDTH-1:0] job_a;
    logic signed [SAMPLE_WIDTH-1:0] job_w [4];
    logic signed [SAMPLE_WIDTH-1:0] eff [4];
    logic [1:0]                     left;

    assign s_ready = adv && (flush_reg == 2'd0);
    assign accept  = s_valid && s_ready;

    always_comb begin
        win_next   = win_reg;
        count_next = count_reg;
        flush_next = flush_reg;
        pad_next   = pad_reg;
        job_valid  = 1'b0;
        job_final  = 1'b0;
        job_a      = pad_reg;
        left       = 2'd0;
        for (int i = 0; i < 4; i++) begin
            job_w[i] = win_reg[i];
            eff[i]   = (count_reg == 2'd0) ? s_sample : win_reg[i];
        end

        if (flush_reg != 2'd0) begin
            // keep pushing the edge sample until the last position is out
            if (adv) begin
                job_valid  = 1'b1;
                job_final  = (flush_reg == 2'd1);
                flush_next = flush_reg - 2'd1;
                if (job_final) begin
                    for (int i = 0; i < 4; i++) win_next[i] = '0;
                end else begin
                    win_next[0] = pad_reg;
                    for (int i = 1; i < 4; i++) win_next[i] = win_reg[i-1];
                end
            end
        end else if (accept) begin
            job_a = s_sample;
            if (!s_last) begin
                job_valid = count_reg[1];
                for (int i = 0; i < 4; i++) job_w[i] = eff[i];
                win_next[0] = s_sample;
                for (int i = 1; i < 4; i++) win_next[i] = eff[i-1];
                count_next = (count_reg == 2'd3) ? 2'd3 : count_reg + 2'd1;
            end else begin
                // one prior sample: its first job already sees one pad shift
                if (count_reg == 2'd1) begin
                    job_w[0] = s_sample;
                    for (int i = 1; i < 4; i++) job_w[i] = win_reg[i-1];
                end else begin
                    for (int i = 0; i < 4; i++) job_w[i] = eff[i];
                end
                left       = count_reg[1] ? 2'd2 : ((count_reg == 2'd1) ? 2'd1 : 2'd0);
                job_valid  = 1'b1;
                job_final  = (left == 2'd0);
                count_next = 2'd0;
                if (left == 2'd0) begin
                    for (int i = 0; i < 4; i++) win_next[i] = '0;
                end else begin
                    win_next[0] = s_sample;
                    for (int i = 1; i < 4; i++) win_next[i] = job_w[i-1];
                    flush_next = left;
                    pad_next   = s_sample;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) win_reg[i] <= '0;
            count_reg    <= 2'd0;
            flush_reg    <= 2'd0;
            job_ctrl_reg <= '0;
        end else begin
            for (int i = 0; i < 4; i++) win_reg[i] <= win_next[i];
            count_reg <= count_next;
            flush_reg <= flush_next;
            if (adv) begin
                job_ctrl_reg.valid    <= job_valid;
                job_ctrl_reg.is_final <= job_final;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pad_reg <= pad_next;
        if (adv) begin
            job_op_reg[0] <= job_a;
            for (int i = 0; i < 4; i++) job_op_reg[i+1] <= job_w[i];
        end
    end

    assign job_ctrl        = job_ctrl_reg;
    assign op_a            = job_op_reg[0];
    assign op_b            = job_op_reg[1];
    assign op_c            = job_op_reg[2];
    assign op_d            = job_op_reg[3];
    assign op_e            = job_op_reg[4];
    assign status.flushing = (flush_reg != 2'd0);

endmodule

// ----- rtl/core/fpd_stencil.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpd_stencil
// Five-tap stencil sum, first or second derivative, as shifts and adds.
// ----------------------------------------------------------------------------
module fpd_stencil
    import fpd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_W_DEF,
    localparam int SUM_W       = SAMPLE_WIDTH + 7
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  logic                           order,
    input  fpd_ctrl_t                      ctrl_in,
    input  logic signed [SAMPLE_WIDTH-1:0] op_a,
    input  logic signed [SAMPLE_WIDTH-1:0] op_b,
    input  logic signed [SAMPLE_WIDTH-1:0] op_c,
    input  logic signed [SAMPLE_WIDTH-1:0] op_d,
    input  logic signed [SAMPLE_WIDTH-1:0] op_e,
    output fpd_ctrl_t                      ctrl_out,
    output logic signed [SUM_W-1:0]        sum_out
);

    logic signed [SUM_W-1:0] a_x, b_x, c_x, d_x, e_x;
    logic signed [SUM_W-1:0] sum_next, sum_reg;
    fpd_ctrl_t               ctrl_reg;

    assign a_x = SUM_W'(op_a);
    assign b_x = SUM_W'(op_b);
    assign c_x = SUM_W'(op_c);
    assign d_x = SUM_W'(op_d);
    assign e_x = SUM_W'(op_e);

    always_comb begin
        case (order)
            ORDER_FIRST:  sum_next = e_x - a_x + (b_x <<< 3) - (d_x <<< 3);
            ORDER_SECOND: sum_next = (b_x <<< 4) + (d_x <<< 4) - (c_x <<< 5)
                                     + (c_x <<< 1) - a_x - e_x;
            default:      sum_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (adv) begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg <= sum_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign sum_out  = sum_reg;

endmodule

// ----- rtl/core/fpd_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpd_scale
// Scales the stencil sum by 16/12 with rounding, saturates, and holds the
// result register.
// ----------------------------------------------------------------------------
module fpd_scale
    import fpd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_W_DEF,
    localparam int SUM_W       = SAMPLE_WIDTH + 7
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  fpd_ctrl_t               ctrl_in,
    input  logic signed [SUM_W-1:0] sum_in,
    output fpd_ctrl_t               ctrl_out,
    output logic [OUT_W-1:0]        derivative
);

    // round(4*S/3) = sign(S) * (|S| + floor((|S|+1)/3)); no ties possible.
    localparam int U_W   = SUM_W - 1;
    localparam int P_W   = 2 * U_W + 1;
    localparam int Q_W   = U_W - 1;
    localparam int EXT_W = (U_W + 1 > OUT_W) ? U_W + 1 : OUT_W;
    // floor(u/3) = (u * ceil(2^(U_W+2)/3)) >> (U_W+2), exact for u < 2^U_W
    localparam logic [63:0]    RECIP_FULL = ((64'd1 << (U_W + 2)) + 64'd2) / 64'd3;
    localparam logic [U_W:0]   RECIP      = RECIP_FULL[U_W:0];
    localparam logic signed [EXT_W-1:0] SAT_HI =
        {{(EXT_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
    localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;

    logic [U_W-1:0]          mag, mag_reg;
    logic [U_W-1:0]          u_val;
    logic [P_W-1:0]          prod_next, prod_reg;
    logic                    neg_reg;
    fpd_ctrl_t               mul_ctrl_reg;
    fpd_ctrl_t               out_ctrl_reg;

    logic [Q_W-1:0]          quo;
    logic [U_W-1:0]          q_mag;
    logic signed [U_W:0]     r_val;
    logic signed [EXT_W-1:0] r_ext;
    logic signed [EXT_W-1:0] r_sat;
    logic [OUT_W-1:0]        out_reg;

    // multiply stage
    assign mag       = sum_in[SUM_W-1] ? U_W'(-sum_in) : U_W'(sum_in);
    assign u_val     = mag + U_W'(1);
    assign prod_next = P_W'(u_val) * P_W'(RECIP);

    // round, sign and clamp stage
    assign quo   = prod_reg[P_W-1 -: Q_W];
    assign q_mag = mag_reg + U_W'(quo);
    assign r_val = neg_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    assign r_ext = EXT_W'(r_val);

    always_comb begin
        if (r_ext > SAT_HI) begin
            r_sat = SAT_HI;
        end else if (r_ext < SAT_LO) begin
            r_sat = SAT_LO;
        end else begin
            r_sat = r_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_ctrl_reg <= '0;
            out_ctrl_reg <= '0;
        end else if (adv) begin
            mul_ctrl_reg <= ctrl_in;
            out_ctrl_reg <= mul_ctrl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag_reg  <= mag;
            neg_reg  <= sum_in[SUM_W-1];
            prod_reg <= prod_next;
            out_reg  <= r_sat[OUT_W-1:0];
        end
    end

    assign ctrl_out   = out_ctrl_reg;
    assign derivative = out_reg;

endmodule

// ----- rtl/core/five_point_derivative_filter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_point_derivative_filter_unit
// Streaming five-point stencil derivative (first or second) divided by 12,
// edge-clamped, with 4 fraction bits.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  tdata (low bit up)              tlast / other
//  --------  ---  ------------------------------  ---------------------------
//  s_*       in   sample [SAMPLE_WIDTH-1:0], pad  tlast = is_last
//  m_*       out  derivative [22:0], pad          tlast = is_final
//  cfg_*     in   cfg_wr_data = derivative_order  written when cfg_wr_en high
//
//  Takes one item per clock while the result side is not stalled. A last item
//  yields up to three results; the input stalls while the front end flushes
//  the window. Four register stages (job, stencil sum, reciprocal multiply,
//  result); an accepted item or a flush step loads the job register, and its
//  result moves through the stages in that order.
//  Reset (aresetn low, synchronous) empties the pipeline and the window and
//  selects the first derivative.
//  All stages advance together whenever the result register is empty or taken.
//
module five_point_derivative_filter_unit
    import fpd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_W_DEF,
    localparam int S_TDATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W   = ((OUT_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // sample, then zero pad
    input  logic                 s_tlast,   // is_last
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // derivative, then zero pad
    output logic                 m_tlast,   // is_final
    // configuration
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data  // derivative_order
);

    localparam int SUM_W = SAMPLE_WIDTH + 7;

    logic                           order_reg;
    logic                           adv;
    fpd_ctrl_t                      job_ctrl, sum_ctrl, out_ctrl;
    fpd_fe_status_t                 fe_status;
    logic signed [SAMPLE_WIDTH-1:0] op_a, op_b, op_c, op_d, op_e;
    logic signed [SUM_W-1:0]        sum_val;
    logic [OUT_W-1:0]               derivative;

    // Stencil select register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= ORDER_FIRST;
        end else if (cfg_wr_en) begin
            order_reg <= cfg_wr_data;
        end
    end

    // Whole pipeline moves when the result register is free.
    assign adv = !out_ctrl.valid || m_tready;

    fpd_window #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .s_valid  (s_tvalid),
        .s_sample ($signed(s_tdata[SAMPLE_WIDTH-1:0])),
        .s_last   (s_tlast),
        .s_ready  (s_tready),
        .job_ctrl (job_ctrl),
        .op_a     (op_a),
        .op_b     (op_b),
        .op_c     (op_c),
        .op_d     (op_d),
        .op_e     (op_e),
        .status   (fe_status)
    );

    fpd_stencil #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_stencil (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .order    (order_reg),
        .ctrl_in  (job_ctrl),
        .op_a     (op_a),
        .op_b     (op_b),
        .op_c     (op_c),
        .op_d     (op_d),
        .op_e     (op_e),
        .ctrl_out (sum_ctrl),
        .sum_out  (sum_val)
    );

    fpd_scale #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .ctrl_in    (sum_ctrl),
        .sum_in     (sum_val),
        .ctrl_out   (out_ctrl),
        .derivative (derivative)
    );

    assign m_tvalid = out_ctrl.valid;
    assign m_tlast  = out_ctrl.is_final;
    assign m_tdata  = M_TDATA_W'(derivative);

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------

    // No new item while the result register is blocked.
    a_ready_needs_room: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!m_tvalid || m_tready)
    ) else $error("input ready while result stage stalled");

    // Input closed during the end-of-vector flush.
    a_flush_blocks_input: assert property (
        @(posedge aclk) disable iff (!aresetn)
        fe_status.flushing |-> !s_tready
    ) else $error("input ready during flush");

    // A flush only starts from an accepted last item.
    a_flush_from_last: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(fe_status.flushing) |-> $past(s_tvalid && s_tready && s_tlast)
    ) else $error("flush started without a last item");

endmodule

// ----- bench/five_point_derivative_filter_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_point_derivative_filter_unit_test
// Self-checking bench for the five-point derivative filter. Vectors of signed
// samples go in over the s_ stream. A local model of the window and the
// stencil predicts every derivative and its final flag. The m_ stream is
// checked in order against those predictions. Both stencil orders are run,
// with directed edge cases first and then random vectors. Both sides insert
// random gaps and stalls, and one phase runs with no idling at all.
// ----------------------------------------------------------------------------
module five_point_derivative_filter_unit_test;
    import fpd_pkg::*;

    localparam int SW          = SAMPLE_W_DEF;
    localparam int DRAIN_WAIT  = 8;     // pipeline depth plus flush steps, rounded up
    localparam int STALL_LIMIT = 1000;  // cycles with no item moving on either side

    // One predicted result item.
    typedef struct {
        logic signed [OUT_W-1:0] deriv;
        logic                    fin;
    } deriv_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [SW-1:0]     s_tdata;     // sample
    logic              s_tlast;     // is_last
    logic              m_tvalid;
    logic              m_tready;
    logic [23:0]       m_tdata;     // derivative [22:0], pad
    logic              m_tlast;     // is_final
    logic              cfg_wr_en;
    logic              cfg_wr_data; // derivative_order

    five_point_derivative_filter_unit #(.SAMPLE_WIDTH(SW)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Model state: window of previous samples (newest first), position
    // count saturating at 3, and the selected stencil.
    logic signed [SW-1:0] hist [4];
    logic [1:0]           pos_cnt;
    logic                 order_sel;

    deriv_t pending_derivs [$];
    int     mismatches;
    bit     no_idle;        // when set, neither side inserts gaps or stalls

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // Stencil on x[i+2], x[i+1], x[i], x[i-1], x[i-2]; result is 4*S/3
    // rounded to nearest (no ties possible), saturated to the output width.
    function automatic logic signed [OUT_W-1:0] stencil_deriv(
        input longint a, input longint b, input longint c,
        input longint d, input longint e
    );
        longint s;
        longint mag;
        longint q;
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (OUT_W - 1)) - 1;
        lo = -hi - 1;
        if (order_sel == ORDER_SECOND) begin
            s = -a + 16 * b - 30 * c + 16 * d - e;
        end else begin
            s = -a + 8 * b - 8 * d + e;
        end
        mag = (s < 0) ? -s : s;
        q   = (mag * 4 + 1) / 3;
        q   = (s < 0) ? -q : q;
        if (q > hi) q = hi;
        if (q < lo) q = lo;
        return q[OUT_W-1:0];
    endfunction

    function automatic void push_deriv(input logic signed [OUT_W-1:0] v,
                                       input logic fin);
        deriv_t r;
        r.deriv = v;
        r.fin   = fin;
        pending_derivs.push_back(r);
    endfunction

    // Advance the model by one accepted item and queue what it yields.
    function automatic void predict_sample(input logic signed [SW-1:0] x,
                                           input logic last);
        if (pos_cnt == 2'd0) begin
            // left edge clamp: window starts full of the first sample
            for (int i = 0; i < 4; i++) hist[i] = x;
        end
        if (!last) begin
            if (pos_cnt >= 2'd2)
                push_deriv(stencil_deriv(x, hist[0], hist[1], hist[2], hist[3]), 1'b0);
            hist[3] = hist[2];
            hist[2] = hist[1];
            hist[1] = hist[0];
            hist[0] = x;
            if (pos_cnt < 2'd3) pos_cnt = pos_cnt + 2'd1;
        end else begin
            // flush; right edge clamped to the last sample
            if (pos_cnt >= 2'd2)
                push_deriv(stencil_deriv(x, hist[0], hist[1], hist[2], hist[3]), 1'b0);
            if (pos_cnt >= 2'd1)
                push_deriv(stencil_deriv(x, x, hist[0], hist[1], hist[2]), 1'b0);
            push_deriv(stencil_deriv(x, x, x, hist[0], hist[1]), 1'b1);
            for (int i = 0; i < 4; i++) hist[i] = '0;
            pos_cnt = 2'd0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Send one item after a random gap; valid stays up after acceptance so
    // back-to-back items need no second assignment in the same step.
    task automatic send_sample(input logic signed [SW-1:0] x, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_sample(x, last);
    endtask

    // Drop valid, drain every expected result, let the pipe go quiet.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_derivs.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_order(input logic ord);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ord;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        order_sel = ord;
    endtask

    function automatic logic signed [SW-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return SW'($signed($urandom_range(0, 16)) - 8);
            default: return SW'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // One-sample vectors: result is zero and marked final.
    task automatic test_single_sample();
        send_sample(16'sh7fff, 1'b1);
        send_sample(16'sh8000, 1'b1);
    endtask

    // Full-scale alternation, the largest stencil magnitudes.
    task automatic test_full_scale();
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b1);
    endtask

    // Two- and three-sample vectors: flush from a partly filled window.
    task automatic test_short_vectors();
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b1);
        send_sample(-16'sd5, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd7, 1'b1);
    endtask

    // Random vectors; mostly short, a few long ones.
    task automatic test_random_vectors(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30)
                                              : $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                send_sample(rand_sample(), k == len - 1);
            end
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, in-order checking
    // ------------------------------------------------------------------------

    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            repeat (stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_tvalid));
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin
        deriv_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_derivs.size() == 0) begin
                report_mismatch($sformatf("unexpected item deriv=%0d last=%0b",
                                          $signed(m_tdata[OUT_W-1:0]), m_tlast));
            end else begin
                want = pending_derivs.pop_front();
                if (m_tdata[OUT_W-1:0] !== want.deriv) begin
                    report_mismatch($sformatf("derivative exp %0d got %0d",
                                              want.deriv, $signed(m_tdata[OUT_W-1:0])));
                end
                if (m_tlast !== want.fin) begin
                    report_mismatch($sformatf("is_final exp %0b got %0b", want.fin, m_tlast));
                end
            end
        end
    end

    // Watchdog: too long without an item moving on either side.
    always @(posedge aclk) begin
        int quiet;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        no_idle     = 1'b0;
        mismatches  = 0;
        for (int i = 0; i < 4; i++) hist[i] = '0;
        pos_cnt   = 2'd0;
        order_sel = ORDER_FIRST;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // first derivative is the reset selection
        test_single_sample();
        test_full_scale();
        test_short_vectors();

        set_order(ORDER_SECOND);
        test_single_sample();
        test_full_scale();
        test_short_vectors();

        set_order(ORDER_FIRST);
        test_random_vectors(40);
        set_order(ORDER_SECOND);
        test_random_vectors(40);

        // back-to-back traffic, no gaps or stalls
        set_order(ORDER_FIRST);
        no_idle = 1'b1;
        test_random_vectors(30);
        no_idle = 1'b0;

        set_order(ORDER_SECOND);
        test_random_vectors(30);

        wait_idle();
        mismatches += pending_derivs.size();
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
